// ----- src/ple_pkg.sv -----
package ple_pkg;

  localparam int VALUE_W      = 32;
  localparam int POS_W        = 7;
  localparam int LEN_W        = 7;
  localparam int CAPACITY_DEF = 64;

  // request opcodes
  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_HEAD   = 3'd1;
  localparam logic [2:0] OP_TAIL   = 3'd2;
  localparam logic [2:0] OP_INSERT = 3'd3;
  localparam logic [2:0] OP_DELETE = 3'd4;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [1:0]         status;
    logic [LEN_W-1:0]   length;
  } res_t;

endpackage

// ----- src/positional_list_engine_unit.sv -----
// Sequence: a read passes through S_READ and S_RESP to the output register,
//   errors go from S_IDLE straight to S_RESP; insert and delete pass through
//   S_SHIFT, where the last move is written back in the cycle after its read,
//   and an insert then stores its value in the element memory before S_RESP.
// Throughput: one request at a time; each shift moves one element per cycle
//   through the single read and write port of the element memory.
// Reset: synchronous, active high; clears the count and control state,
//   the element memory is not cleared.
module positional_list_engine_unit #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] opcode, [9:3] position, [41:10] item_value, [47:42] zero
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [31:0] read_value, [33:32] status, [40:34] length_now, [47:41] zero
  output logic [47:0] m_tdata
);
  import ple_pkg::*;

  logic res_valid, res_take;
  res_t res;
  res_t out_res;

  // output register, refilled as it is taken
  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign m_tdata = {7'd0, out_res.length, out_res.status, out_res.value};

  ple_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .opcode     (s_tdata[2:0]),
    .position   (s_tdata[9:3]),
    .item_value (s_tdata[41:10]),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

endmodule

// ----- src/ple_ram.sv -----
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/ple_ctrl.sv -----
module ple_ctrl #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  opcode,
  input  logic [ple_pkg::POS_W-1:0]   position,
  input  logic [ple_pkg::VALUE_W-1:0] item_value,
  output logic                        res_valid,
  input  logic                        res_take,
  output ple_pkg::res_t               res
);
  import ple_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0]         state;
  logic [CW-1:0]      count;
  logic [AW-1:0]      rd_ptr;
  logic [CW-1:0]      left;
  logic               pend;
  logic [AW-1:0]      pend_addr;
  logic               up;
  logic [AW-1:0]      ins_pos;
  logic [VALUE_W-1:0] ins_val;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [VALUE_W-1:0] ram_wdata, ram_rdata;

  logic          accept;
  logic [XW-1:0] pos_x, cnt_x, pos_sel;
  logic          is_full;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state == S_RESP);
  assign pos_x     = XW'(position);
  assign cnt_x     = XW'(count);
  assign is_full   = (count == CW'(CAPACITY));

  // target position of an insert
  always_comb begin
    case (opcode)
      OP_HEAD: pos_sel = '0;
      OP_TAIL: pos_sel = cnt_x;
      default: pos_sel = pos_x;
    endcase
  end

  // memory port steering
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = rd_ptr;
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = ram_rdata;
    if (state == S_IDLE) begin
      ram_re    = accept && (opcode == OP_READ) && (pos_x < cnt_x);
      ram_raddr = AW'(pos_x);
    end else if (state == S_SHIFT) begin
      ram_re = (left != '0);
      if (pend) begin
        ram_we = 1'b1;
      end else if (left == '0 && up) begin
        ram_we    = 1'b1;
        ram_waddr = ins_pos;
        ram_wdata = ins_val;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            res.value  <= '0;
            res.status <= ST_DONE;
            res.length <= LEN_W'(count);
            pend       <= 1'b0;
            ins_val    <= item_value;
            ins_pos    <= AW'(pos_sel);
            case (opcode)
              OP_READ: begin
                if (pos_x < cnt_x) begin
                  state <= S_READ;
                end else begin
                  res.value  <= '1;
                  res.status <= ST_RANGE;
                  state      <= S_RESP;
                end
              end
              OP_HEAD, OP_TAIL, OP_INSERT: begin
                if (pos_sel > cnt_x) begin
                  res.status <= ST_RANGE;
                  state      <= S_RESP;
                end else if (is_full) begin
                  res.status <= ST_FULL;
                  state      <= S_RESP;
                end else begin
                  up     <= 1'b1;
                  rd_ptr <= AW'(count - 1'b1);
                  left   <= CW'(cnt_x - pos_sel);
                  state  <= S_SHIFT;
                end
              end
              OP_DELETE: begin
                if (pos_x < cnt_x) begin
                  up     <= 1'b0;
                  rd_ptr <= AW'(pos_x + 1'b1);
                  left   <= CW'(cnt_x - pos_x - 1'b1);
                  state  <= S_SHIFT;
                end else begin
                  res.status <= ST_RANGE;
                  state      <= S_RESP;
                end
              end
              default: begin
                res.status <= ST_RANGE;
                state      <= S_RESP;
              end
            endcase
          end
        end
        S_READ: begin
          res.value <= ram_rdata;
          state     <= S_RESP;
        end
        S_SHIFT: begin
          // one element moved a cycle: read now, write back next cycle
          if (left != '0) begin
            pend      <= 1'b1;
            pend_addr <= up ? AW'(rd_ptr + 1'b1) : AW'(rd_ptr - 1'b1);
            rd_ptr    <= up ? AW'(rd_ptr - 1'b1) : AW'(rd_ptr + 1'b1);
            left      <= left - 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (left == '0 && !pend) begin
            count      <= up ? CW'(count + 1'b1) : CW'(count - 1'b1);
            res.length <= up ? LEN_W'(count + 1'b1) : LEN_W'(count - 1'b1);
            state      <= S_RESP;
          end
        end
        S_RESP: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ple_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- src/ple_checker.sv -----
module ple_checker #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);
  import ple_pkg::*;

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // full status only when the list is at capacity
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33:32] == ST_FULL |-> m_tdata[40:34] == 7'(CAPACITY))
    else $error("full status below capacity");

  // failed requests return 0 or all ones
  a_errval: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33:32] != ST_DONE |->
      m_tdata[31:0] == '0 || m_tdata[31:0] == '1)
    else $error("bad value on error");

  // ready for a request straight after reset
  a_rst: assert property (@(posedge clk)
    $past(rst) && !rst |-> s_tready && !m_tvalid)
    else $error("not idle after reset");

endmodule

bind positional_list_engine_unit ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (.*);

// ----- dv/ple_checker.sv -----
`timescale 1ns / 100ps

module ple_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  output int          fail_count,
  output int          pending
);
  import ple_pkg::*;

  localparam int CAP = CAPACITY_DEF;

  logic [VALUE_W-1:0] list_cells[CAP];
  int                 list_len;
  res_t               result_queue[$];

  // work out the result of one request and update the list copy
  function automatic res_t list_apply(logic [2:0] op, logic [POS_W-1:0] pos,
                                      logic [VALUE_W-1:0] val);
    res_t r;
    int   p;
    r.value  = '0;
    r.status = ST_DONE;
    p = pos;
    if (op == OP_HEAD) p = 0;
    if (op == OP_TAIL) p = list_len;
    case (op)
      OP_READ: begin
        if (p < list_len) r.value = list_cells[p];
        else begin
          r.value  = '1;
          r.status = ST_RANGE;
        end
      end
      OP_HEAD, OP_TAIL, OP_INSERT: begin
        if (p > list_len) r.status = ST_RANGE;
        else if (list_len >= CAP) r.status = ST_FULL;
        else begin
          for (int i = list_len; i > p; i--) list_cells[i] = list_cells[i-1];
          list_cells[p] = val;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (p < list_len) begin
          for (int i = p; i < list_len - 1; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end else r.status = ST_RANGE;
      end
      default: r.status = ST_RANGE;
    endcase
    r.length = list_len[LEN_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      list_len = 0;
      fail_count <= 0;
      pending    <= 0;
      result_queue.delete();
    end else begin
      if (s_tvalid && s_tready)
        result_queue.push_back(list_apply(s_tdata[2:0], s_tdata[9:3], s_tdata[41:10]));
      if (m_tvalid && m_tready) begin
        got.value  = m_tdata[31:0];
        got.status = m_tdata[33:32];
        got.length = m_tdata[40:34];
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = result_queue.pop_front();
          if (got !== want || m_tdata[47:41] !== '0) begin
            $display("%0t: mismatch expected value %h status %0d length %0d, got %h %0d %0d",
                     $time, want.value, want.status, want.length,
                     got.value, got.status, got.length);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= result_queue.size();
    end
  end

endmodule

// ----- dv/positional_list_engine_unit_tb.sv -----
`timescale 1ns / 100ps

module positional_list_engine_unit_tb;
  import ple_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  bit          hold_sink = 1'b0;
  bit          no_gaps = 1'b0;
  int          fill_level = 0;

  always #5 clk = ~clk;

  positional_list_engine_unit u_dut (.*);

  ple_scoreboard u_chk (.*);

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 900000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // sink side: random stalls, plus one long hold-off
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      m_tready <= 1'b0;
    end
  end

  // one request, held until it transfers
  task automatic send_request(logic [2:0] op, logic [POS_W-1:0] pos,
                              logic [VALUE_W-1:0] val, bit pause);
    int gap;
    gap = (pause && !no_gaps) ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, val, pos, op};
    do @(posedge clk); while (!s_tready);
    if ((op == OP_HEAD || op == OP_TAIL || (op == OP_INSERT && pos <= fill_level))
        && fill_level < CAPACITY_DEF) fill_level++;
    if (op == OP_DELETE && pos < fill_level) fill_level--;
    if (fill_level > CAPACITY_DEF) fill_level = CAPACITY_DEF;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int k;
    int op;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list cases, then a short list, then fill to full, then edges
    send_request(OP_READ, 7'd0, 32'd0, 1);
    send_request(OP_DELETE, 7'd0, 32'd0, 1);
    send_request(OP_INSERT, 7'd1, 32'h1234_5678, 1);
    send_request(3'd5, 7'd0, 32'hFFFF_FFFF, 1);
    send_request(3'd7, 7'd127, 32'h0, 1);
    send_request(OP_HEAD, 7'd0, 32'h8000_0000, 1);
    send_request(OP_TAIL, 7'd127, 32'h7FFF_FFFF, 1);
    send_request(OP_INSERT, 7'd1, 32'hFFFF_FFFF, 1);
    send_request(OP_READ, 7'd2, 32'h0, 1);
    send_request(OP_READ, 7'd3, 32'h0, 1);
    send_request(OP_INSERT, 7'd127, 32'hAAAA_5555, 1);
    send_request(OP_DELETE, 7'd1, 32'h0, 1);
    send_request(OP_DELETE, 7'd64, 32'h0, 1);
    send_request(3'd6, 7'h55, 32'h5555_AAAA, 1);
    // fill to capacity with no gaps; sink held off so the block stalls
    hold_sink = 1'b1;
    while (fill_level < CAPACITY_DEF)
      send_request(OP_TAIL, 7'h2A, $urandom, 0);
    send_request(OP_HEAD, 7'd0, 32'h1, 0);
    send_request(OP_INSERT, 7'd64, 32'h2, 0);
    send_request(OP_INSERT, 7'd65, 32'h3, 0);
    send_request(OP_READ, 7'd63, 32'h0, 0);
    send_request(OP_READ, 7'd64, 32'h0, 0);
    send_request(OP_DELETE, 7'd63, 32'h0, 0);
    send_request(OP_DELETE, 7'd0, 32'h0, 0);
    wait_drained();

    // random: mostly in-range positions, some noise and stretches without gaps
    for (k = 0; k < 600; k++) begin
      no_gaps = ((k / 100) % 3 == 2);
      op = $urandom_range(0, 19);
      if (op < 5) op = OP_READ;
      else if (op < 8) op = OP_HEAD;
      else if (op < 11) op = OP_TAIL;
      else if (op < 14) op = OP_INSERT;
      else if (op < 18) op = OP_DELETE;
      else op = $urandom_range(5, 7);
      if ($urandom_range(0, 9) == 0)
        send_request(op[2:0], POS_W'($urandom), $urandom, 1);
      else
        send_request(op[2:0], POS_W'($urandom_range(0, fill_level)), $urandom, 1);
      if (k == 300) wait_drained();
    end
    no_gaps = 1'b0;

    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
